// ===== rtl/freefall_impact_fall_detector_macros.svh =====
// Assertion macros shared by the fall detector RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef FREEFALL_IMPACT_FALL_DETECTOR_MACROS_SVH
`define FREEFALL_IMPACT_FALL_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFD_ASSERT_SAME(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
`define FFD_ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define FFD_ASSERT_SAME(label, a, b, msg)
`define FFD_ASSERT_NEXT(label, a, b, msg)
`endif
`endif

// ===== rtl/ffd_pkg.sv =====
// Package of the fall detector: widths, register indexes, reset values and
// the command struct between controller and datapath. No dependencies.
`default_nettype none

package ffd_pkg;

    localparam int AXIS_W     = 16;
    localparam int FIELD_W    = 16;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 32;
    localparam int MAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 3 * FIELD_W + TIME_W;
    localparam int OUT_DATA_W = 24;
    localparam int STEP_W     = 4;
    localparam int SQ_STEPS   = 4;
    localparam int ROOT_STEPS = SUM_W / 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_DELTA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARMED_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE       = 3'd5;

    // 6.0, 50.0 and 20.0 m/s^2 at 3.9 mg per count.
    localparam logic [15:0] RST_FREEFALL_LIMIT = 16'd157;
    localparam logic [15:0] RST_FREEFALL_MIN   = 16'd200;
    localparam logic [15:0] RST_IMPACT_LIMIT   = 16'd1307;
    localparam logic [15:0] RST_IMPACT_DELTA   = 16'd523;
    localparam logic [31:0] RST_ARMED_WINDOW   = 32'd1000;
    localparam logic [31:0] RST_DEBOUNCE       = 32'd1000;
    localparam logic [MAG_W-1:0] RST_PREV_MAG  = 16'd256;

    // Selects for the shared squaring multiplier; the last one feeds zero.
    localparam logic [1:0] SQ_SEL_X    = 2'd0;
    localparam logic [1:0] SQ_SEL_Y    = 2'd1;
    localparam logic [1:0] SQ_SEL_Z    = 2'd2;
    localparam logic [1:0] SQ_SEL_NONE = 2'd3;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_step;
        logic       eval;
        logic       commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ffd_datapath.sv =====
// Datapath of the fall detector: axis magnitude, square root, detection state,
// configuration registers and the result register. Depends on ffd_pkg.
`default_nettype none

module ffd_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ffd_pkg::ctrl_cmd_t               cmd,
    input  wire logic [ffd_pkg::IN_DATA_W-1:0]    in_data,
    input  wire logic                             cfg_we,
    input  wire logic [ffd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ffd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [ffd_pkg::OUT_DATA_W-1:0]        out_data
);

    function automatic logic [ffd_pkg::AXIS_W-1:0] axis_abs(
        input logic [ffd_pkg::FIELD_W-1:0] raw
    );
        logic [ffd_pkg::AXIS_W-1:0] v;
        v = raw[ffd_pkg::AXIS_W-1:0];
        // The most negative value maps onto itself, read as unsigned.
        if (v[ffd_pkg::AXIS_W-1])
        begin
            axis_abs = ~v + 1'b1;
        end
        else
        begin
            axis_abs = v;
        end
    endfunction

    // Configuration registers.
    logic [15:0] ff_limit_reg;
    logic [15:0] ff_min_reg;
    logic [15:0] imp_limit_reg;
    logic [15:0] imp_delta_reg;
    logic [31:0] window_reg;
    logic [31:0] debounce_reg;

    // Per-item working registers.
    logic [ffd_pkg::AXIS_W-1:0]   ax_reg, ay_reg, az_reg;
    logic [ffd_pkg::TIME_W-1:0]   now_reg;
    logic [ffd_pkg::SUM_W-1:0]    prod_reg;
    logic [ffd_pkg::SUM_W-1:0]    rem_reg;
    logic [ffd_pkg::SUM_W-1:0]    root_reg;
    logic [ffd_pkg::SUM_W-1:0]    bit_reg;
    logic [ffd_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Flags from the evaluation step.
    logic        ff_hit_reg;
    logic        arm_now_reg;
    logic        expired_reg;
    logic        impact_hit_reg;
    logic        deb_ok_reg;
    logic [15:0] cnt_inc_reg;

    // Detection state.
    logic [15:0]                  samples_reg;
    logic                         armed_reg;
    logic [ffd_pkg::TIME_W-1:0]   armed_since_reg;
    logic [ffd_pkg::TIME_W-1:0]   last_fall_reg;
    logic [ffd_pkg::MAG_W-1:0]    prev_mag_reg;

    logic [ffd_pkg::AXIS_W-1:0]   sq_operand;
    logic [ffd_pkg::SUM_W-1:0]    sq_next;
    logic [ffd_pkg::SUM_W-1:0]    trial;
    logic [ffd_pkg::MAG_W-1:0]    mag;
    logic [ffd_pkg::MAG_W-1:0]    delta;
    logic [15:0]                  cnt_inc;
    logic [ffd_pkg::TIME_W-1:0]   since_armed;
    logic [ffd_pkg::TIME_W-1:0]   since_fall;
    logic                         armed_after;
    logic                         impact;
    logic                         fall;
    logic [15:0]                  samples_after;

    always_comb
    begin
        case (cmd.sq_sel)
            ffd_pkg::SQ_SEL_X: sq_operand = ax_reg;
            ffd_pkg::SQ_SEL_Y: sq_operand = ay_reg;
            ffd_pkg::SQ_SEL_Z: sq_operand = az_reg;
            default:           sq_operand = '0;
        endcase
    end

    assign sq_next = ffd_pkg::SUM_W'(sq_operand * sq_operand);
    assign trial   = root_reg + bit_reg;
    assign mag     = root_reg[ffd_pkg::MAG_W-1:0];
    assign delta   = (mag >= prev_mag_reg) ? (mag - prev_mag_reg) : (prev_mag_reg - mag);
    assign cnt_inc = (samples_reg == 16'hFFFF) ? samples_reg : samples_reg + 16'd1;
    assign since_armed = now_reg - armed_since_reg;
    assign since_fall  = now_reg - last_fall_reg;

    // Commit: arming, then timeout, then impact, in that order.
    always_comb
    begin
        armed_after   = armed_reg | arm_now_reg;
        samples_after = ff_hit_reg ? cnt_inc_reg : (armed_reg ? samples_reg : 16'd0);
        if (expired_reg)
        begin
            armed_after   = 1'b0;
            samples_after = 16'd0;
        end
        impact = armed_after & impact_hit_reg;
        fall   = impact & deb_ok_reg;
        if (impact)
        begin
            armed_after   = 1'b0;
            samples_after = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_limit_reg  <= ffd_pkg::RST_FREEFALL_LIMIT;
            ff_min_reg    <= ffd_pkg::RST_FREEFALL_MIN;
            imp_limit_reg <= ffd_pkg::RST_IMPACT_LIMIT;
            imp_delta_reg <= ffd_pkg::RST_IMPACT_DELTA;
            window_reg    <= ffd_pkg::RST_ARMED_WINDOW;
            debounce_reg  <= ffd_pkg::RST_DEBOUNCE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ffd_pkg::CFG_FREEFALL_LIMIT: ff_limit_reg  <= cfg_data[15:0];
                ffd_pkg::CFG_FREEFALL_MIN:   ff_min_reg    <= cfg_data[15:0];
                ffd_pkg::CFG_IMPACT_LIMIT:   imp_limit_reg <= cfg_data[15:0];
                ffd_pkg::CFG_IMPACT_DELTA:   imp_delta_reg <= cfg_data[15:0];
                ffd_pkg::CFG_ARMED_WINDOW:   window_reg    <= cfg_data;
                ffd_pkg::CFG_DEBOUNCE:       debounce_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg     <= '0;
            armed_reg       <= 1'b0;
            armed_since_reg <= '0;
            last_fall_reg   <= '0;
            prev_mag_reg    <= ffd_pkg::RST_PREV_MAG;
        end
        else if (cmd.commit)
        begin
            samples_reg  <= samples_after;
            armed_reg    <= armed_after;
            prev_mag_reg <= mag;
            if (arm_now_reg)
            begin
                armed_since_reg <= now_reg;
            end
            if (fall)
            begin
                last_fall_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg   <= axis_abs(in_data[ffd_pkg::FIELD_W-1:0]);
            ay_reg   <= axis_abs(in_data[2*ffd_pkg::FIELD_W-1:ffd_pkg::FIELD_W]);
            az_reg   <= axis_abs(in_data[3*ffd_pkg::FIELD_W-1:2*ffd_pkg::FIELD_W]);
            now_reg  <= in_data[ffd_pkg::IN_DATA_W-1:3*ffd_pkg::FIELD_W];
            prod_reg <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= ffd_pkg::SUM_W'(1) << (ffd_pkg::SUM_W - 2);
        end
        else if (cmd.sq_step)
        begin
            // The product lands one step after its multiply; rem holds the sum.
            prod_reg <= sq_next;
            rem_reg  <= rem_reg + prod_reg;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (cmd.eval)
        begin
            ff_hit_reg     <= mag < ff_limit_reg;
            cnt_inc_reg    <= cnt_inc;
            arm_now_reg    <= (mag < ff_limit_reg) && (cnt_inc >= ff_min_reg) && !armed_reg;
            expired_reg    <= armed_reg && (since_armed > window_reg);
            impact_hit_reg <= (mag > imp_limit_reg) && (delta >= imp_delta_reg);
            deb_ok_reg     <= since_fall > debounce_reg;
        end

        if (cmd.commit)
        begin
            out_data_reg <= {6'd0, armed_after, mag, fall};
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ffd_ctrl.sv =====
// Controller of the fall detector: sequences load, squaring, square root,
// evaluation and commit, and owns both handshakes. Depends on ffd_pkg.
`default_nettype none

module ffd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ffd_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ROOT   = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    localparam logic [ffd_pkg::STEP_W-1:0] SQ_LAST   = ffd_pkg::STEP_W'(ffd_pkg::SQ_STEPS - 1);
    localparam logic [ffd_pkg::STEP_W-1:0] ROOT_LAST =
        ffd_pkg::STEP_W'(ffd_pkg::ROOT_STEPS - 1);

    logic [2:0]                   state_reg, state_next;
    logic [ffd_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.sq_sel     = step_reg[1:0];
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_step = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == SQ_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == ROOT_LAST)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // The detection state moves only together with its result.
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/freefall_impact_fall_detector.sv =====
// Fall detector top level: a request is accepted, taken through 4 squaring steps,
// 16 square-root steps, one evaluation step and one commit step. A new request
// is accepted only after the previous result is committed, and commit waits
// while the output still holds a result that has not been taken.
// Reset (rst_n, asynchronous, active low) restores register defaults and
// clears the detection state; previous magnitude resets to one g (256 counts).
`default_nettype none
`include "freefall_impact_fall_detector_macros.svh"

module freefall_impact_fall_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
    input  wire logic [ffd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // fall_detected [0], magnitude [16:1], armed [17], zero [23:18]
    output logic [ffd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [ffd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ffd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ffd_pkg::ctrl_cmd_t cmd;

    ffd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    ffd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

    `FFD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while an item was still in work")
    `FFD_ASSERT_SAME(a_commit_slot_free, cmd.commit, !m_axis_tvalid || m_axis_tready,
        "result committed over one that was not yet taken")
    `FFD_ASSERT_SAME(a_fall_disarms, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[17],
        "fall reported while still armed")
    `FFD_ASSERT_SAME(a_one_command, cmd.load || cmd.sq_step || cmd.root_step,
        !cmd.eval && !cmd.commit, "evaluation overlaps the arithmetic steps")

endmodule

`default_nettype wire

// ===== sim/fall_detector_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the fall detector: watches the sample, result and register
// channels, predicts every result and compares it. Depends on ffd_pkg only.
module fall_detector_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
    input  logic [ffd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // fall_detected [0], magnitude [16:1], armed [17], zero [23:18]
    input  logic [ffd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import ffd_pkg::*;

    typedef struct packed {
        logic [OUT_DATA_W-MAG_W-3:0] pad;
        logic                        armed;
        logic [MAG_W-1:0]            magnitude;
        logic                        fall_detected;
    } report_t;

    // Shadow copy of the thresholds.
    logic [15:0] ff_limit;
    logic [15:0] ff_needed;
    logic [15:0] hit_limit;
    logic [15:0] hit_jump;
    logic [31:0] arm_window;
    logic [31:0] quiet_period;

    // Detection state as the block should hold it.
    logic [15:0] ff_count;
    logic        armed_now;
    logic [31:0] armed_at;
    logic [31:0] last_fall_at;
    logic [15:0] prev_mag;

    report_t queued_reports[$];
    report_t want;
    report_t got;

    function automatic logic [31:0] axis_abs(input logic [FIELD_W-1:0] raw);
        logic [AXIS_W-1:0] a;
        logic [AXIS_W-1:0] neg;
        a   = raw[AXIS_W-1:0];
        neg = ~a + 1'b1;
        return a[AXIS_W-1] ? 32'(neg) : 32'(a);
    endfunction

    // Largest r with r*r <= n, settled one bit at a time from the top.
    function automatic logic [15:0] floor_root(input logic [31:0] n);
        logic [15:0] r;
        logic [15:0] t;
        r = '0;
        for (int i = 15; i >= 0; i--) begin
            t = r | (16'd1 << i);
            if (32'(t) * 32'(t) <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic report_t evaluate_sample(input logic [IN_DATA_W-1:0] d);
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] now;
        logic [15:0] mag;
        logic [15:0] jump;
        report_t     rep;
        ax  = axis_abs(d[0 +: FIELD_W]);
        ay  = axis_abs(d[FIELD_W +: FIELD_W]);
        az  = axis_abs(d[2*FIELD_W +: FIELD_W]);
        now = d[3*FIELD_W +: TIME_W];
        mag = floor_root(ax * ax + ay * ay + az * az);
        rep = '0;
        rep.magnitude = mag;

        if (mag < ff_limit) begin
            if (ff_count != 16'hFFFF)
                ff_count++;
            if (ff_count >= ff_needed && !armed_now) begin
                armed_now = 1'b1;
                armed_at  = now;
            end
        end else if (!armed_now) begin
            ff_count = '0;
        end

        // An expired window is dropped before any impact is looked at.
        if (armed_now && (now - armed_at) > arm_window) begin
            armed_now = 1'b0;
            ff_count  = '0;
        end

        jump = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
        if (armed_now && mag > hit_limit && jump >= hit_jump) begin
            if ((now - last_fall_at) > quiet_period) begin
                rep.fall_detected = 1'b1;
                last_fall_at      = now;
            end
            armed_now = 1'b0;
            ff_count  = '0;
        end

        prev_mag  = mag;
        rep.armed = armed_now;
        return rep;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ff_limit     = RST_FREEFALL_LIMIT;
            ff_needed    = RST_FREEFALL_MIN;
            hit_limit    = RST_IMPACT_LIMIT;
            hit_jump     = RST_IMPACT_DELTA;
            arm_window   = RST_ARMED_WINDOW;
            quiet_period = RST_DEBOUNCE;
            ff_count     = '0;
            armed_now    = 1'b0;
            armed_at     = '0;
            last_fall_at = '0;
            prev_mag     = RST_PREV_MAG;
            queued_reports.delete();
            fail_count   = 0;
            pending      = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FREEFALL_LIMIT: ff_limit     = cfg_data[15:0];
                    CFG_FREEFALL_MIN:   ff_needed    = cfg_data[15:0];
                    CFG_IMPACT_LIMIT:   hit_limit    = cfg_data[15:0];
                    CFG_IMPACT_DELTA:   hit_jump     = cfg_data[15:0];
                    CFG_ARMED_WINDOW:   arm_window   = cfg_data;
                    CFG_DEBOUNCE:       quiet_period = cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                queued_reports.push_back(evaluate_sample(s_axis_tdata));

            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (queued_reports.size() == 0) begin
                    $display("%0t ns: result with no request outstanding, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = queued_reports.pop_front();
                    check_field("fall_detected", 32'(want.fall_detected),
                                32'(got.fall_detected));
                    check_field("magnitude", 32'(want.magnitude), 32'(got.magnitude));
                    check_field("armed", 32'(want.armed), 32'(got.armed));
                    check_field("padding", 32'(want.pad), 32'(got.pad));
                end
            end
            pending = queued_reports.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the fall detector bench: clock, reset, register setup, sample
// stimulus and result stalls. Depends on ffd_pkg, the RTL and the checker.
module testbench;
    import ffd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;

    // Thresholds currently programmed, used to shape the samples.
    logic [15:0] set_limit;
    logic [15:0] set_min;
    logic [31:0] set_window;
    logic [31:0] clock_ms;
    int          burst_left = 0;
    int          hold = 0;

    always #10 clk = ~clk;

    freefall_impact_fall_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fall_detector_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // The upper half of a 16-bit register write carries junk on purpose.
    task automatic apply_settings(input logic [15:0] limit, input logic [15:0] min_count,
                                  input logic [15:0] impact, input logic [15:0] jump,
                                  input logic [31:0] window, input logic [31:0] hold_off);
        set_limit  = limit;
        set_min    = min_count;
        set_window = window;
        write_reg(CFG_FREEFALL_LIMIT, {16'($urandom), limit});
        write_reg(CFG_FREEFALL_MIN, {16'($urandom), min_count});
        write_reg(CFG_IMPACT_LIMIT, {16'($urandom), impact});
        write_reg(CFG_IMPACT_DELTA, {16'($urandom), jump});
        write_reg(CFG_ARMED_WINDOW, window);
        write_reg(CFG_DEBOUNCE, hold_off);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer(input logic [IN_DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_sample(input int x, input int y, input int z, input logic [31:0] t);
        clock_ms = t;
        offer({t, 16'(z), 16'(y), 16'(x)});
    endtask

    // Waits until every request has produced its result, then lets the
    // pipeline drain before registers are touched again.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        burst_left = 0;
    endtask

    function automatic int strong_axis();
        int a;
        a = $urandom_range(16384, 32768);
        if ($urandom_range(0, 1) == 1)
            return -a;
        return (a > 32767) ? 32767 : a;
    endfunction

    // Each axis within half the limit keeps the magnitude below the limit.
    task automatic send_quiet();
        int h;
        h = set_limit / 2;
        send_sample(int'($urandom_range(0, 2 * h)) - h, int'($urandom_range(0, 2 * h)) - h,
                    int'($urandom_range(0, 2 * h)) - h, clock_ms + $urandom_range(0, 20));
    endtask

    task automatic send_rest();
        send_sample(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40,
                    int'($urandom_range(216, 296)), clock_ms + $urandom_range(0, 20));
    endtask

    task automatic send_impact();
        logic [31:0] step;
        if ($urandom_range(0, 3) == 0)
            step = set_window + $urandom_range(0, 2) - 1;
        else
            step = $urandom_range(0, 20);
        send_sample(strong_axis(), strong_axis(), strong_axis(), clock_ms + step);
    endtask

    task automatic send_noise();
        logic [31:0] t;
        t = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms + $urandom_range(0, 50);
        send_sample(int'($urandom), int'($urandom), int'($urandom), t);
    endtask

    // Mostly free-fall runs closed by an impact, with rest and noise between.
    task automatic run_phase(input int n_items);
        int sent;
        int k;
        int kind;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                if ($urandom_range(0, 3) == 0)
                    clock_ms = clock_ms + $urandom_range(200, 3000);
                if ($urandom_range(0, 15) == 0)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
                k = (set_min > 10) ? 10 : set_min;
                k = k + $urandom_range(0, 2);
                if (k > 0 && $urandom_range(0, 5) == 0)
                    k--;
                repeat (k) begin
                    send_quiet();
                    sent++;
                end
                repeat ($urandom_range(0, 2)) begin
                    send_rest();
                    sent++;
                end
                send_impact();
                sent++;
            end else if (kind < 8) begin
                repeat ($urandom_range(1, 5)) begin
                    send_rest();
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_noise();
                    sent++;
                end
            end
        end
        settle();
    endtask

    // Result side: a stall pattern picked at random from four modes, plus two
    // long hold-offs so that the block backs up into its input.
    initial begin : receive_side
        int tick;
        int mode;
        tick = 0;
        mode = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            if (tick == 2500 || tick == 15000)
                hold = 400;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        set_limit  = RST_FREEFALL_LIMIT;
        set_min    = RST_FREEFALL_MIN;
        set_window = RST_ARMED_WINDOW;
        clock_ms   = '0;

        // Magnitude extremes under the power-on thresholds.
        send_sample(0, 0, 0, 32'd0);
        send_sample(32767, 32767, 32767, 32'd1);
        send_sample(-32768, -32768, -32768, 32'd2);
        send_sample(-32768, 0, 32767, 32'd3);
        send_sample(1, -1, 0, 32'hFFFF_FFFF);
        send_sample(0, 0, 256, 32'h8000_0000);
        settle();

        apply_settings(16'd157, 16'd1, 16'd1307, 16'd523, 32'd1000, 32'd1000);
        // A fall this close to time zero is swallowed by the start-up debounce.
        send_sample(10, -20, 30, 32'd5);
        send_sample(20000, -20000, 20000, 32'd10);
        send_sample(10, -20, 30, 32'd2000);
        send_sample(20000, -20000, 20000, 32'd2001);
        send_sample(10, -20, 30, 32'd2500);
        send_sample(20000, -20000, 20000, 32'd2600);
        // The window runs out on the very sample that would be the impact.
        send_sample(10, -20, 30, 32'd3700);
        send_sample(20000, -20000, 20000, 32'd4701);
        // Arming just before the timestamp wraps.
        send_sample(10, -20, 30, 32'hFFFF_FFF0);
        send_sample(20000, -20000, 20000, 32'd8);
        // Elapsed time equal to the window still counts as armed.
        send_sample(10, -20, 30, 32'd100);
        send_sample(20000, -20000, 20000, 32'd1100);
        // Under the impact limit, then over it with too small a jump, then exactly the jump.
        send_sample(10, -20, 30, 32'd3000);
        send_sample(0, 0, 1000, 32'd3001);
        send_sample(0, 0, 1400, 32'd3002);
        send_sample(0, 0, 1923, 32'd3003);
        settle();

        // A sample count of zero arms on the first free-fall sample.
        apply_settings(16'd157, 16'd0, 16'd1307, 16'd523, 32'd1000, 32'd1000);
        send_sample(10, -20, 30, 32'd5000);
        send_sample(0, 0, 156, 32'd5001);
        send_sample(0, 0, 157, 32'd5002);
        send_sample(-32768, 32767, -32768, 32'd5003);
        settle();

        apply_settings(16'd157, 16'd3, 16'd1307, 16'd523, 32'd1000, 32'd1000);
        run_phase(90);
        apply_settings(16'hFFFF, 16'd1, 16'd0, 16'd0, 32'd0, 32'd0);
        run_phase(60);
        apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(40);
        apply_settings(16'd200, 16'd0, 16'd1000, 16'd0, 32'hFFFF_FFFF, 32'd0);
        run_phase(60);
        repeat (3) begin
            apply_settings(16'($urandom_range(50, 3000)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 30000)), 16'($urandom_range(0, 20000)),
                           $urandom_range(0, 300), $urandom_range(0, 400));
            run_phase(70);
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ffd_pkg.sv
rtl/ffd_datapath.sv
rtl/ffd_ctrl.sv
rtl/freefall_impact_fall_detector.sv
sim/fall_detector_checker.sv
sim/testbench.sv
